>>> rtl/pidtc_pkg.sv
// Shared types, widths and constants of the trapezoidal PID controller.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package pidtc_pkg;

   localparam int SAMPLE_W   = 12;
   localparam int GAIN_W     = 16;
   localparam int ERR_W      = 13;
   localparam int DIFF_W     = 14;
   localparam int SUM_W      = 32;
   localparam int PP_W       = GAIN_W + 1 + ERR_W;
   localparam int PI_W       = GAIN_W + 1 + SUM_W;
   localparam int PD_W       = GAIN_W + 1 + DIFF_W;
   localparam int NUM_W      = 56;
   localparam int DEN_SHIFT  = 13;
   localparam int X_W        = 20;
   localparam int RECIP_W    = 21;
   localparam int RECIP_SHIFT = 28;
   localparam int QPROD_W    = X_W + RECIP_W;
   localparam int Q_W        = QPROD_W - RECIP_SHIFT;

   localparam int REQ_DATA_W   = 24;
   localparam int RSP_DATA_W   = 16;
   localparam int CSR_INDEX_W  = 8;
   localparam int CSR_DATA_W   = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_PROPORTIONAL_GAIN = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INTEGRAL_GAIN     = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DERIVATIVE_GAIN   = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CONTROL_ENABLE    = 8'd3;

   localparam logic [SAMPLE_W-1:0] FULL_CODE = 12'hFFF;

   // The drive numerator is 660*Gp*e + 33*Gi*S + 2000*Gd*d over 2048*660.
   localparam logic signed [NUM_W-1:0] P_SCALE     = 56'sd660;
   localparam logic signed [NUM_W-1:0] I_SCALE     = 56'sd33;
   localparam logic signed [NUM_W-1:0] D_SCALE     = 56'sd2000;
   localparam logic signed [NUM_W-1:0] HALF_DEN    = 56'sd675840;
   localparam logic signed [NUM_W-1:0] CLAMP_LIMIT = 56'sd5535129600;

   // The denominator is 2^13 * 165; this is ceil(2^28 / 165).
   localparam logic [RECIP_W-1:0] RECIP_165 = 21'd1626882;

   localparam logic signed [SUM_W-1:0] SUM_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [SUM_W-1:0] SUM_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic [GAIN_W-1:0] proportional_gain;
      logic [GAIN_W-1:0] integral_gain;
      logic [GAIN_W-1:0] derivative_gain;
      logic              control_enable;
   } pidtc_cfg_type;

   typedef struct packed {
      logic                     enable;
      logic signed [ERR_W-1:0]  err;
      logic signed [SUM_W-1:0]  sum;
      logic signed [DIFF_W-1:0] diff;
   } pidtc_err_type;

   typedef struct packed {
      logic                    enable;
      logic signed [NUM_W-1:0] num;
   } pidtc_num_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] drive_code;
      logic                clamped_high;
      logic                clamped_low;
   } pidtc_out_type;

endpackage

`default_nettype wire

>>> rtl/pidtc_error_stage.sv
// Input register, error state and saturating trapezoid integral update.
// Depends on pidtc_pkg for widths, limits and the stage structs.
`timescale 1ns / 1ps
`default_nettype none

module pidtc_error_stage (
   input  logic                             clock,
   input  logic                             reset,
   input  pidtc_pkg::pidtc_cfg_type         cfg,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  logic [pidtc_pkg::SAMPLE_W-1:0]   plant_code,
   input  logic [pidtc_pkg::SAMPLE_W-1:0]   setpoint_code,
   output logic                             out_valid,
   input  logic                             out_ready,
   output pidtc_pkg::pidtc_err_type         out_data
);
   import pidtc_pkg::*;

   logic                     a_valid_ff;
   logic [SAMPLE_W-1:0]      plant_ff;
   logic [SAMPLE_W-1:0]      setpoint_ff;
   logic                     b_valid_ff;
   pidtc_err_type            b_ff;
   pidtc_err_type            b_in;
   logic signed [ERR_W-1:0]  last_error_ff;
   logic signed [SUM_W-1:0]  integral_ff;
   logic signed [SUM_W-1:0]  integral_in;
   logic signed [ERR_W-1:0]  err_in;
   logic signed [DIFF_W-1:0] pair_in;
   logic signed [DIFF_W-1:0] diff_in;
   logic [SUM_W:0]           sum_wide;
   logic                     b_ready;
   logic                     a_fire;

   assign b_ready  = !b_valid_ff || out_ready;
   assign a_fire   = a_valid_ff && b_ready;
   assign in_ready = !a_valid_ff || b_ready;

   always_comb begin
      err_in   = {1'b0, setpoint_ff} - {1'b0, plant_ff};
      pair_in  = {err_in[ERR_W-1], err_in} + {last_error_ff[ERR_W-1], last_error_ff};
      diff_in  = {err_in[ERR_W-1], err_in} - {last_error_ff[ERR_W-1], last_error_ff};
      sum_wide = {integral_ff[SUM_W-1], integral_ff}
               + {{(SUM_W - DIFF_W + 1){pair_in[DIFF_W-1]}}, pair_in};
      if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
         integral_in = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
      end else begin
         integral_in = sum_wide[SUM_W-1:0];
      end
      b_in.enable = cfg.control_enable;
      b_in.err    = err_in;
      b_in.sum    = integral_in;
      b_in.diff   = diff_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff    <= 1'b0;
         b_valid_ff    <= 1'b0;
         last_error_ff <= '0;
         integral_ff   <= '0;
      end else begin
         if (in_ready) begin
            a_valid_ff <= in_valid;
         end
         if (b_ready) begin
            b_valid_ff <= a_valid_ff;
         end
         if (a_fire && cfg.control_enable) begin
            last_error_ff <= err_in;
            integral_ff   <= integral_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         plant_ff    <= plant_code;
         setpoint_ff <= setpoint_code;
      end
      if (a_fire) begin
         b_ff <= b_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_data  = b_ff;

endmodule

`default_nettype wire

>>> rtl/pidtc_product_stage.sv
// Gain products, constant scaling and the summed drive numerator, three stages.
// Depends on pidtc_pkg for widths, scale constants and the stage structs.
`timescale 1ns / 1ps
`default_nettype none

module pidtc_product_stage (
   input  logic                     clock,
   input  logic                     reset,
   input  pidtc_pkg::pidtc_cfg_type cfg,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  pidtc_pkg::pidtc_err_type in_data,
   output logic                     out_valid,
   input  logic                     out_ready,
   output pidtc_pkg::pidtc_num_type out_data
);
   import pidtc_pkg::*;

   logic                    c_valid_ff;
   logic                    c_en_ff;
   logic signed [PP_W-1:0]  prod_p_ff;
   logic signed [PI_W-1:0]  prod_i_ff;
   logic signed [PD_W-1:0]  prod_d_ff;
   logic signed [PP_W-1:0]  prod_p_in;
   logic signed [PI_W-1:0]  prod_i_in;
   logic signed [PD_W-1:0]  prod_d_in;
   logic                    d_valid_ff;
   logic                    d_en_ff;
   logic signed [NUM_W-1:0] term_p_ff;
   logic signed [NUM_W-1:0] term_i_ff;
   logic signed [NUM_W-1:0] term_d_ff;
   logic signed [NUM_W-1:0] term_p_in;
   logic signed [NUM_W-1:0] term_i_in;
   logic signed [NUM_W-1:0] term_d_in;
   logic                    e_valid_ff;
   pidtc_num_type           e_ff;
   pidtc_num_type           e_in;
   logic                    c_ready;
   logic                    d_ready;
   logic                    e_ready;

   assign e_ready  = !e_valid_ff || out_ready;
   assign d_ready  = !d_valid_ff || e_ready;
   assign c_ready  = !c_valid_ff || d_ready;
   assign in_ready = c_ready;

   always_comb begin
      prod_p_in = $signed({1'b0, cfg.proportional_gain}) * in_data.err;
      prod_i_in = $signed({1'b0, cfg.integral_gain}) * in_data.sum;
      prod_d_in = $signed({1'b0, cfg.derivative_gain}) * in_data.diff;
      term_p_in = NUM_W'(prod_p_ff) * P_SCALE;
      term_i_in = NUM_W'(prod_i_ff) * I_SCALE;
      term_d_in = NUM_W'(prod_d_ff) * D_SCALE;
      e_in.enable = d_en_ff;
      e_in.num    = term_p_ff + term_i_ff + term_d_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
      end else begin
         if (c_ready) begin
            c_valid_ff <= in_valid;
         end
         if (d_ready) begin
            d_valid_ff <= c_valid_ff;
         end
         if (e_ready) begin
            e_valid_ff <= d_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (c_ready && in_valid) begin
         c_en_ff   <= in_data.enable;
         prod_p_ff <= prod_p_in;
         prod_i_ff <= prod_i_in;
         prod_d_ff <= prod_d_in;
      end
      if (d_ready && c_valid_ff) begin
         d_en_ff   <= c_en_ff;
         term_p_ff <= term_p_in;
         term_i_ff <= term_i_in;
         term_d_ff <= term_d_in;
      end
      if (e_ready && d_valid_ff) begin
         e_ff <= e_in;
      end
   end

   assign out_valid = e_valid_ff;
   assign out_data  = e_ff;

endmodule

`default_nettype wire

>>> rtl/pidtc_quant_stage.sv
// Clamp decision, rounding and division by 2048*660, ending in the result register.
// Depends on pidtc_pkg for the clamp limit, the reciprocal and the stage structs.
`timescale 1ns / 1ps
`default_nettype none

module pidtc_quant_stage (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  pidtc_pkg::pidtc_num_type in_data,
   output logic                     out_valid,
   input  logic                     out_ready,
   output pidtc_pkg::pidtc_out_type out_data
);
   import pidtc_pkg::*;

   logic                    f_valid_ff;
   logic                    f_en_ff;
   logic                    f_high_ff;
   logic                    f_low_ff;
   logic [X_W-1:0]          f_x_ff;
   logic signed [NUM_W-1:0] rounded;
   logic                    g_valid_ff;
   pidtc_out_type           g_ff;
   pidtc_out_type           g_in;
   logic [QPROD_W-1:0]      qprod;
   logic [Q_W-1:0]          quotient;
   logic                    f_ready;
   logic                    g_ready;

   assign g_ready  = !g_valid_ff || out_ready;
   assign f_ready  = !f_valid_ff || g_ready;
   assign in_ready = f_ready;
   assign rounded  = in_data.num + HALF_DEN;

   always_comb begin
      qprod    = QPROD_W'(f_x_ff) * QPROD_W'(RECIP_165);
      quotient = qprod[QPROD_W-1:RECIP_SHIFT];
      g_in.clamped_high = f_en_ff && f_high_ff;
      g_in.clamped_low  = f_en_ff && !f_high_ff && f_low_ff;
      if (!f_en_ff || f_low_ff) begin
         g_in.drive_code = '0;
      end else if (f_high_ff || quotient > Q_W'(FULL_CODE)) begin
         g_in.drive_code = FULL_CODE;
      end else begin
         g_in.drive_code = quotient[SAMPLE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
         g_valid_ff <= 1'b0;
      end else begin
         if (f_ready) begin
            f_valid_ff <= in_valid;
         end
         if (g_ready) begin
            g_valid_ff <= f_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (f_ready && in_valid) begin
         f_en_ff   <= in_data.enable;
         f_high_ff <= in_data.num > CLAMP_LIMIT;
         f_low_ff  <= in_data.num[NUM_W-1];
         f_x_ff    <= rounded[DEN_SHIFT+X_W-1:DEN_SHIFT];
      end
      if (g_ready && f_valid_ff) begin
         g_ff <= g_in;
      end
   end

   assign out_valid = g_valid_ff;
   assign out_data  = g_ff;

endmodule

`default_nettype wire

>>> rtl/pid_trapezoid_clamped.sv
// PID controller with trapezoidal integral and clamped 12-bit drive.
// Top level: register port, stream ports, and the three pipeline stage modules.
// Depends on pidtc_pkg, pidtc_error_stage, pidtc_product_stage, pidtc_quant_stage.
//
// The req channel takes one word per control tick holding a plant sample and a
// setpoint sample. The rsp channel returns one word per request: the drive code
// and the high and low clamp flags. The csr channel writes the three Q5.11 gains
// and the enable bit; csr_ready is always high and unknown indexes are ignored.
// Gains should be written only while no request is in flight.
//
// The datapath is a seven-register pipeline with a valid bit per stage, and a new
// request can be taken every cycle while rsp keeps taking words. Each stage moves
// forward whenever the stage after it is empty or moving, so a stalled receiver
// fills the pipeline before req_tready drops, and it rises again as soon as rsp
// takes a word.
// Reset clears the gains, the enable bit, the error and integral state and all
// stage valid bits; with control disabled the drive is zero and the state holds.
`timescale 1ns / 1ps
`default_nettype none

module pid_trapezoid_clamped (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // plant_code[11:0], setpoint_code[23:12]
   input  logic [pidtc_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // drive_code[11:0], clamped_high[12], clamped_low[13], zero[15:14]
   output logic [pidtc_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [pidtc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [pidtc_pkg::CSR_DATA_W-1:0]   csr_data
);
   import pidtc_pkg::*;

   pidtc_cfg_type cfg_ff;
   logic          err_valid;
   logic          err_ready;
   pidtc_err_type err_data;
   logic          num_valid;
   logic          num_ready;
   pidtc_num_type num_data;
   pidtc_out_type out_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_PROPORTIONAL_GAIN: cfg_ff.proportional_gain <= csr_data;
            CSR_INTEGRAL_GAIN:     cfg_ff.integral_gain     <= csr_data;
            CSR_DERIVATIVE_GAIN:   cfg_ff.derivative_gain   <= csr_data;
            CSR_CONTROL_ENABLE:    cfg_ff.control_enable    <= csr_data[0];
            default: ;
         endcase
      end
   end

   pidtc_error_stage u_error (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .in_valid      (req_tvalid),
      .in_ready      (req_tready),
      .plant_code    (req_tdata[SAMPLE_W-1:0]),
      .setpoint_code (req_tdata[2*SAMPLE_W-1:SAMPLE_W]),
      .out_valid     (err_valid),
      .out_ready     (err_ready),
      .out_data      (err_data)
   );

   pidtc_product_stage u_product (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (err_valid),
      .in_ready  (err_ready),
      .in_data   (err_data),
      .out_valid (num_valid),
      .out_ready (num_ready),
      .out_data  (num_data)
   );

   pidtc_quant_stage u_quant (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (num_valid),
      .in_ready  (num_ready),
      .in_data   (num_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_data)
   );

   assign rsp_tdata = {2'b00, out_data.clamped_low, out_data.clamped_high,
                       out_data.drive_code};

endmodule

`default_nettype wire

>>> rtl/pidtc_checker.sv
// Port-level checks of the PID controller's result channel, and the bind to the top.
// Depends on pidtc_pkg for the result word width.
`timescale 1ns / 1ps
`default_nettype none

module pidtc_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [pidtc_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import pidtc_pkg::*;

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp word dropped while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("rsp word changed while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[SAMPLE_W] && rsp_tdata[SAMPLE_W+1]))
      else $error("both clamp flags set");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[SAMPLE_W] |-> rsp_tdata[SAMPLE_W-1:0] == FULL_CODE)
      else $error("high clamp without full-scale drive");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[SAMPLE_W+1] |-> rsp_tdata[SAMPLE_W-1:0] == '0)
      else $error("low clamp without zero drive");

endmodule

bind pid_trapezoid_clamped pidtc_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

>>> verif/tb_top.sv
// Self-checking bench for the trapezoidal PID controller: stream stimulus, register
// writes and a cycle-free predictor of drive code and clamp flags for every word.
// Depends on pidtc_pkg and pid_trapezoid_clamped.
`timescale 1ns / 1ps

module tb_top;
   import pidtc_pkg::*;

   localparam longint NUM_FULL = 64'sd5535129600;
   localparam longint NUM_HALF = 64'sd675840;
   localparam longint NUM_DEN  = 64'sd1351680;
   localparam int     MAX_PRINTED = 50;

   typedef struct packed {
      logic [SAMPLE_W-1:0] plant;
      logic [SAMPLE_W-1:0] setpoint;
   } sample_pair_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_data   = '0;

   logic [GAIN_W-1:0] kp_gain   = '0;
   logic [GAIN_W-1:0] ki_gain   = '0;
   logic [GAIN_W-1:0] kd_gain   = '0;
   logic              loop_on   = 1'b0;
   int                last_err  = 0;
   int                integ_sum = 0;

   sample_pair_type sample_q[$];
   pidtc_out_type   drive_q[$];
   sample_pair_type sent_pair;
   pidtc_out_type   want_word;

   int mismatch_count = 0;
   int accepted_items = 0;
   int burst_left     = 0;
   int gap_left       = 0;
   int hold_left      = 0;
   int stall_mode     = 0;
   int stall_cycle    = 0;
   bit no_idle        = 1'b0;
   bit long_hold_done = 1'b0;
   bit ready_next;

   pid_trapezoid_clamped u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic pidtc_out_type pid_drive(input sample_pair_type s);
      pidtc_out_type r;
      int            err_now;
      int            err_step;
      longint        total;
      longint        num;
      longint        code;
      r = '0;
      if (loop_on) begin
         err_now = int'(s.setpoint) - int'(s.plant);
         total = longint'(integ_sum) + longint'(err_now + last_err);
         if (total > longint'(SUM_MAX)) begin
            integ_sum = SUM_MAX;
         end else if (total < longint'(SUM_MIN)) begin
            integ_sum = SUM_MIN;
         end else begin
            integ_sum = int'(total);
         end
         err_step = err_now - last_err;
         num = 64'sd660 * longint'(kp_gain) * longint'(err_now)
             + 64'sd33 * longint'(ki_gain) * longint'(integ_sum)
             + 64'sd2000 * longint'(kd_gain) * longint'(err_step);
         if (num > NUM_FULL) begin
            r.drive_code   = FULL_CODE;
            r.clamped_high = 1'b1;
         end else if (num < 0) begin
            r.clamped_low = 1'b1;
         end else begin
            code = (num + NUM_HALF) / NUM_DEN;
            r.drive_code = code[SAMPLE_W-1:0];
         end
         last_err = err_now;
      end
      return r;
   endfunction

   task automatic flag_mismatch(input string field, input longint got, input longint want);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTED) begin
         $display("mismatch in %s: got %0d, want %0d at %0t", field, got, want, $time);
      end
   endtask

   task automatic apply_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      case (idx)
         CSR_PROPORTIONAL_GAIN: kp_gain = value;
         CSR_INTEGRAL_GAIN:     ki_gain = value;
         CSR_DERIVATIVE_GAIN:   kd_gain = value;
         CSR_CONTROL_ENABLE:    loop_on = value[0];
         default: ;
      endcase
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      apply_reg(idx, value);
   endtask

   task automatic write_gains(input int kp, input int ki, input int kd, input int enable_word);
      write_reg(CSR_PROPORTIONAL_GAIN, kp[CSR_DATA_W-1:0]);
      write_reg(CSR_INTEGRAL_GAIN, ki[CSR_DATA_W-1:0]);
      write_reg(CSR_DERIVATIVE_GAIN, kd[CSR_DATA_W-1:0]);
      write_reg(CSR_CONTROL_ENABLE, enable_word[CSR_DATA_W-1:0]);
   endtask

   task automatic push_pair(input int plant, input int setpoint);
      sample_pair_type p;
      p.plant    = plant[SAMPLE_W-1:0];
      p.setpoint = setpoint[SAMPLE_W-1:0];
      sample_q.push_back(p);
   endtask

   task automatic wait_idle();
      while (sample_q.size() != 0 || req_tvalid || drive_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   function automatic int pick_gain();
      int g;
      case ($urandom_range(0, 5))
         0: g = 0;
         1: g = 40960;
         2: g = 65535;
         3: g = $urandom_range(0, 65535);
         default: g = $urandom_range(0, 4096);
      endcase
      return g;
   endfunction

   task automatic add_random_item();
      int kind;
      int base;
      int off;
      kind = $urandom_range(0, 9);
      base = $urandom_range(0, 4095);
      case (kind)
         0, 1: push_pair($urandom_range(0, 4095), base);
         8:    push_pair($urandom_range(0, 1) * 4095, $urandom_range(0, 1) * 4095);
         9:    push_pair(base, base);
         default: begin
            off = $urandom_range(0, 64);
            off = base + off - 32;
            if (off < 0) off = 0;
            if (off > 4095) off = 4095;
            push_pair(off, base);
         end
      endcase
   endtask

   // Sender: bursts of words separated by random gaps; valid holds until taken.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            sent_pair = sample_q.pop_front();
            drive_q.push_back(pid_drive(sent_pair));
            accepted_items++;
         end
         if (req_tvalid && !req_tready) begin
         end else if (gap_left > 0 && !no_idle) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (sample_q.size() > 0) begin
            req_tvalid <= 1'b1;
            req_tdata  <= {sample_q[0].setpoint, sample_q[0].plant};
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(0, 24);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver: a stall pattern that changes every so often, plus one long hold and rare random holds.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         stall_cycle++;
         if (stall_cycle % 97 == 0) stall_mode = $urandom_range(0, 3);
         if (hold_left > 0) begin
            hold_left--;
            ready_next = 1'b0;
         end else if (!long_hold_done && accepted_items >= 400) begin
            long_hold_done = 1'b1;
            hold_left      = 80;
            ready_next     = 1'b0;
         end else if (no_idle) begin
            ready_next = 1'b1;
         end else if ($urandom_range(0, 999) == 0) begin
            hold_left  = $urandom_range(20, 60);
            ready_next = 1'b0;
         end else begin
            case (stall_mode)
               0: ready_next = 1'b1;
               1: ready_next = $urandom_range(0, 1);
               2: ready_next = (stall_cycle % 4 == 0);
               default: ready_next = ($urandom_range(0, 7) != 0);
            endcase
         end
         rsp_tready <= ready_next;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (drive_q.size() == 0) begin
            flag_mismatch("unexpected word", rsp_tdata, -1);
         end else begin
            want_word = drive_q.pop_front();
            if (rsp_tdata[11:0] !== want_word.drive_code)
               flag_mismatch("drive_code", rsp_tdata[11:0], want_word.drive_code);
            if (rsp_tdata[12] !== want_word.clamped_high)
               flag_mismatch("clamped_high", rsp_tdata[12], want_word.clamped_high);
            if (rsp_tdata[13] !== want_word.clamped_low)
               flag_mismatch("clamped_low", rsp_tdata[13], want_word.clamped_low);
            if (rsp_tdata[15:14] !== 2'b00)
               flag_mismatch("pad bits", rsp_tdata[15:14], 0);
         end
      end
   end

   initial begin
      int     phase;
      int     n;
      int     pl;
      int     enable_word;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Loop disabled out of reset: zero drive, state untouched.
      push_pair(0, 4095);
      push_pair(4095, 0);
      push_pair(4095, 4095);
      wait_idle();

      write_gains(2048, 2048, 2048, 1);
      push_pair(0, 0);
      push_pair(0, 4095);
      push_pair(4095, 0);
      push_pair(0, 4095);
      push_pair(2048, 2047);
      push_pair(1000, 1000);
      wait_idle();

      // Proportional only: exactly full scale is not flagged, negative clamps low.
      write_gains(2048, 0, 0, 1);
      push_pair(0, 4095);
      push_pair(1, 0);
      push_pair(7, 7);
      wait_idle();

      // Half gain: odd errors land on a half code and round up.
      write_reg(CSR_PROPORTIONAL_GAIN, 16'd1024);
      push_pair(0, 1);
      push_pair(0, 3);
      push_pair(0, 4095);
      push_pair(4095, 0);
      wait_idle();

      // Writes to indexes past the register map must change nothing.
      write_reg(8'd4, 16'hFFFF);
      write_reg(8'd255, 16'hFFFF);
      push_pair(0, 1);
      wait_idle();

      write_reg(CSR_CONTROL_ENABLE, 16'hFFFE);
      push_pair(0, 4095);
      wait_idle();

      write_gains(65535, 65535, 65535, 16'h0001);
      push_pair(4095, 0);
      push_pair(0, 4095);
      push_pair(2048, 2048);
      wait_idle();

      for (phase = 0; phase < 12; phase++) begin
         enable_word = $urandom_range(0, 65535);
         enable_word[0] = ($urandom_range(0, 4) != 0);
         write_reg(CSR_PROPORTIONAL_GAIN, CSR_DATA_W'(pick_gain()));
         write_reg(CSR_INTEGRAL_GAIN, CSR_DATA_W'(pick_gain()));
         write_reg(CSR_DERIVATIVE_GAIN, CSR_DATA_W'(pick_gain()));
         write_reg(CSR_INDEX_W'($urandom_range(4, 255)), CSR_DATA_W'($urandom_range(0, 65535)));
         write_reg(CSR_CONTROL_ENABLE, enable_word[CSR_DATA_W-1:0]);
         n = $urandom_range(110, 150);
         repeat (n) add_random_item();
         wait_idle();
      end

      // Back-to-back words with neither side idle: a long run of large error
      // builds the integral, then a strong proportional term pulls against it.
      no_idle = 1'b1;
      write_gains(65535, 1, 0, 1);
      repeat (40) push_pair(0, 4095);
      repeat (30) begin
         pl = $urandom_range(1700, 4095);
         push_pair(pl, pl - $urandom_range(1575, 1700));
      end
      wait_idle();

      repeat (40) push_pair(4095, 0);
      repeat (30) begin
         pl = $urandom_range(0, 2395);
         push_pair(pl, pl + $urandom_range(1575, 1700));
      end
      wait_idle();

      repeat (20) @(posedge clock);
      if (drive_q.size() != 0) flag_mismatch("words still outstanding", drive_q.size(), 0);
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #40_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

>>> pid_trapezoid_clamped.f
rtl/pidtc_pkg.sv
rtl/pidtc_error_stage.sv
rtl/pidtc_product_stage.sv
rtl/pidtc_quant_stage.sv
rtl/pid_trapezoid_clamped.sv
rtl/pidtc_checker.sv
verif/tb_top.sv
